### design/pitot_as_pkg.sv
package pitot_as_pkg;

    // Converter and pressure scaling.
    localparam int ADC_BITS = 10;
    localparam int ADC_FS = (1 << ADC_BITS) - 1;
    localparam int P_SCALE = 3300;
    localparam int P_OFFSET = 2500;
    localparam int Q_W = 12;
    localparam int X_W = ADC_BITS + Q_W;
    localparam int PRES_W = 13;
    localparam int DIFF_W = 14;
    localparam int REL_W = 12;

    // Square root and filter widths.
    localparam int RAD_W = 32;
    localparam int ROOT_W = 16;
    localparam int SQREM_W = 18;
    localparam int SQ_STEPS = 16;
    localparam int SQ_CNT_W = 5;
    localparam int AIR_W = 16;
    localparam int FILT_W = 24;
    localparam int COEF_W = 16;
    localparam int PROD_A_W = COEF_W + FILT_W;
    localparam int PROD_B_W = COEF_W + ROOT_W;
    localparam logic [COEF_W-1:0] Q15_ONE = 16'd32768;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd22938;
    localparam logic [COEF_W-1:0] RATIO_RESET = 16'd8166;

    // Configuration register map.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LPF_COEF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITOT_RATIO = 1'd1;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                recalibrate;
    } in_item_t;

    typedef struct packed {
        logic [AIR_W-1:0] airspeed;
        logic [REL_W-1:0] relative_pressure;
        logic             calibrating;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mulx;
        logic est;
        logic corr;
        logic cal_acc;
        logic div_load;
        logic div_step;
        logic set_off;
        logic rel;
        logic sq_load;
        logic sq_step;
        logic mulf1;
        logic mulf2;
        logic acc;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_cal;
        logic cal_full;
        logic sq_last;
    } dp_sts_t;

endpackage

### design/pitot_as_ctrl.sv
module pitot_as_ctrl
    import pitot_as_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_MULX   = 13'b0000000000010,
        ST_EST    = 13'b0000000000100,
        ST_CORR   = 13'b0000000001000,
        ST_CALACC = 13'b0000000010000,
        ST_DIV    = 13'b0000000100000,
        ST_SETOFF = 13'b0000001000000,
        ST_REL    = 13'b0000010000000,
        ST_SQLD   = 13'b0000100000000,
        ST_SQRT   = 13'b0001000000000,
        ST_MULF1  = 13'b0010000000000,
        ST_MULF2  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   acc_pending_reg, acc_pending_next;

    // Sequencing of one transaction through the datapath.
    always_comb begin
        cmd = '0;
        state_next = state_reg;
        acc_pending_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                cmd.mulx = 1'b1;
                state_next = ST_EST;
            end
            ST_EST: begin
                cmd.est = 1'b1;
                state_next = ST_CORR;
            end
            ST_CORR: begin
                cmd.corr = 1'b1;
                if (sts.in_cal) begin
                    if (sts.cal_full) begin
                        cmd.div_load = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_CALACC;
                    end
                end else begin
                    state_next = ST_REL;
                end
            end
            ST_CALACC: begin
                cmd.cal_acc = 1'b1;
                state_next = ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next = ST_SETOFF;
            end
            ST_SETOFF: begin
                cmd.set_off = 1'b1;
                state_next = ST_OUT;
            end
            ST_REL: begin
                cmd.rel = 1'b1;
                state_next = ST_SQLD;
            end
            ST_SQLD: begin
                cmd.sq_load = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sq_step = 1'b1;
                if (sts.sq_last) begin
                    state_next = ST_MULF1;
                end
            end
            ST_MULF1: begin
                cmd.mulf1 = 1'b1;
                state_next = ST_MULF2;
            end
            ST_MULF2: begin
                cmd.mulf2 = 1'b1;
                acc_pending_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // The filter sum lands on the first cycle here.
                cmd.acc = acc_pending_reg;
                if (!acc_pending_reg && (!m_valid_reg || m_ready)) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    acc_pending_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid is held until the receiver takes the transaction.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_pending_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            acc_pending_reg <= acc_pending_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // An accepted transaction keeps the input closed on the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after accepting a transaction");

    // A new result is loaded only when the output register is free.
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transaction");

    // The offset multiply is always followed by the offset store.
    a_div_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |=> state_reg == ST_SETOFF)
        else $error("offset multiply did not finish in one cycle");
`endif

endmodule

### design/pitot_as_dp.sv
module pitot_as_dp
    import pitot_as_pkg::*;
#(
    parameter int CAL_LENGTH = 100
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_item_t              s_data,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    localparam int CNT_W = $clog2(CAL_LENGTH + 1);
    localparam int MAG_W = $clog2(P_OFFSET * CAL_LENGTH + 1);
    localparam int SUM_W = MAG_W + 1;
    // Rounded-up reciprocal of the window length; exact for every sum below 2**MAG_W.
    localparam int DIV_L = $clog2(CAL_LENGTH);
    localparam int DIV_SH = MAG_W + DIV_L;
    localparam int DIV_M_W = MAG_W + 1;
    localparam int DPROD_W = MAG_W + DIV_M_W;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(((64'd1 << DIV_SH)
        + 64'(CAL_LENGTH) - 64'd1) / 64'(CAL_LENGTH));

    // Configuration registers.
    logic [COEF_W-1:0] lpf_coef_reg;
    logic [COEF_W-1:0] pitot_ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpf_coef_reg <= COEF_RESET;
            pitot_ratio_reg <= RATIO_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LPF_COEF:    lpf_coef_reg <= cfg_wdata;
                REG_PITOT_RATIO: pitot_ratio_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pressure conversion: adc * 3300 / full scale, done with a reciprocal series
    // and one correction step, then shifted down by the sensor offset.
    logic [ADC_BITS-1:0]   adc_reg;
    logic [X_W-1:0]        x_reg;
    logic [Q_W-1:0]        q_est_reg;
    logic signed [PRES_W-1:0] p_reg;
    logic [X_W:0]          y_sum;
    logic [X_W-1:0]        q_times_fs;
    logic [X_W-1:0]        x_rem;
    logic [Q_W-1:0]        q_fix;

    always_comb begin
        y_sum = {1'b0, x_reg} + (X_W + 1)'(x_reg >> ADC_BITS)
            + (X_W + 1)'(x_reg >> (2 * ADC_BITS));
        q_times_fs = {q_est_reg, ADC_BITS'(0)} - X_W'(q_est_reg);
        x_rem = x_reg - q_times_fs;
        q_fix = (x_rem >= X_W'(ADC_FS)) ? q_est_reg + Q_W'(1) : q_est_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            adc_reg <= s_data.adc_sample;
        end
        if (cmd.mulx) begin
            x_reg <= X_W'(adc_reg) * X_W'(P_SCALE);
        end
        if (cmd.est) begin
            q_est_reg <= Q_W'(y_sum >> ADC_BITS);
        end
        if (cmd.corr) begin
            p_reg <= $signed({1'b0, q_fix}) - PRES_W'(P_OFFSET);
        end
    end

    // Calibration state and the offset divider, a multiply by the reciprocal
    // of the window length.
    logic [CNT_W-1:0]          cal_count_reg;
    logic signed [SUM_W-1:0]   cal_sum_reg;
    logic signed [PRES_W-1:0]  zero_offset_reg;
    logic                      in_cal_reg;
    logic                      item_cal_reg;
    logic [MAG_W-1:0]          dmag_reg;
    logic                      dneg_reg;
    logic [DPROD_W-1:0]        dprod_reg;
    logic [MAG_W-1:0]          sum_mag;
    logic [PRES_W-1:0]         quot;

    always_comb begin
        sum_mag = cal_sum_reg[SUM_W-1] ? MAG_W'(-cal_sum_reg) : MAG_W'(cal_sum_reg);
        quot = {1'b0, dprod_reg[DIV_SH +: Q_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg <= '0;
            cal_sum_reg <= '0;
            zero_offset_reg <= '0;
            in_cal_reg <= 1'b1;
        end else begin
            if (cmd.accept && s_data.recalibrate) begin
                cal_count_reg <= '0;
                cal_sum_reg <= '0;
                in_cal_reg <= 1'b1;
            end
            if (cmd.cal_acc) begin
                cal_count_reg <= cal_count_reg + CNT_W'(1);
                cal_sum_reg <= cal_sum_reg + SUM_W'(p_reg);
            end
            if (cmd.set_off) begin
                zero_offset_reg <= dneg_reg ? -$signed(quot) : $signed(quot);
                in_cal_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.corr) begin
            item_cal_reg <= in_cal_reg;
        end
        if (cmd.div_load) begin
            dmag_reg <= sum_mag;
            dneg_reg <= cal_sum_reg[SUM_W-1];
        end
        if (cmd.div_step) begin
            dprod_reg <= DPROD_W'(dmag_reg) * DPROD_W'(DIV_M);
        end
    end

    // Relative pressure and the bit-serial square root, two bits per step.
    logic signed [DIFF_W-1:0] diff;
    logic [REL_W-1:0]         rel_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [SQREM_W-1:0]       sqrem_reg;
    logic [SQ_CNT_W-1:0]      sq_cnt_reg;
    logic [SQREM_W+1:0]       sqrem_sh;
    logic [SQREM_W+1:0]       sq_trial;
    logic                     sq_ge;

    always_comb begin
        diff = DIFF_W'(p_reg) - DIFF_W'(zero_offset_reg);
        sqrem_sh = {sqrem_reg, rad_reg[RAD_W-1 -: 2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge = sqrem_sh >= sq_trial;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rel) begin
            rel_reg <= (diff > 0) ? diff[REL_W-1:0] : '0;
        end
        if (cmd.sq_load) begin
            rad_reg <= {(RAD_W - 4)'(rel_reg * pitot_ratio_reg), 4'b0000};
            root_reg <= '0;
            sqrem_reg <= '0;
            sq_cnt_reg <= SQ_CNT_W'(SQ_STEPS);
        end else if (cmd.sq_step) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            sqrem_reg <= sq_ge ? SQREM_W'(sqrem_sh - sq_trial) : SQREM_W'(sqrem_sh);
            sq_cnt_reg <= sq_cnt_reg - SQ_CNT_W'(1);
        end
    end

    // Low-pass filter: coef*old + (1-coef)*s, rounded half up, Q8.16 state.
    logic [COEF_W-1:0]   coef_c;
    logic [PROD_A_W-1:0] prod_a_reg;
    logic [PROD_B_W-1:0] prod_b_reg;
    logic [FILT_W-1:0]   filt_reg;
    logic [PROD_A_W:0]   acc_sum;
    logic [PROD_A_W-15:0] acc_sh;
    logic [FILT_W-1:0]   filt_new;

    always_comb begin
        coef_c = (lpf_coef_reg > Q15_ONE) ? Q15_ONE : lpf_coef_reg;
        acc_sum = {1'b0, prod_a_reg} + (PROD_A_W + 1)'({prod_b_reg, 8'h00})
            + (PROD_A_W + 1)'(16384);
        acc_sh = acc_sum[PROD_A_W:15];
        filt_new = (|acc_sh[PROD_A_W-15:FILT_W]) ? '1 : acc_sh[FILT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (cmd.accept && s_data.recalibrate) begin
            filt_reg <= '0;
        end else if (cmd.acc) begin
            filt_reg <= filt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mulf1) begin
            prod_a_reg <= coef_c * filt_reg;
        end
        if (cmd.mulf2) begin
            prod_b_reg <= (Q15_ONE - coef_c) * root_reg;
        end
    end

    // Output register.
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.calibrating <= item_cal_reg;
            m_data_reg.airspeed <= item_cal_reg ? '0 : filt_reg[FILT_W-1 -: AIR_W];
            m_data_reg.relative_pressure <= item_cal_reg ? '0 : rel_reg;
        end
    end

    assign m_data = m_data_reg;

    assign sts.in_cal = in_cal_reg;
    assign sts.cal_full = (cal_count_reg == CNT_W'(CAL_LENGTH));
    assign sts.sq_last = (sq_cnt_reg == SQ_CNT_W'(1));

`ifndef SYNTHESIS
    // The zero offset always lies within the range of converted pressures.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_offset_reg >= -13'sd2500 && zero_offset_reg <= 13'sd800)
        else $error("zero offset outside the pressure range");

    // Storing the offset ends calibration.
    a_cal_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_off |=> !in_cal_reg)
        else $error("calibration did not end after offset update");

    // The calibration count never runs past the window length.
    a_cal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_count_reg <= CNT_W'(CAL_LENGTH))
        else $error("calibration count past the window length");
`endif

endmodule

### design/pitot_airspeed_estimator.sv
// Pitot airspeed estimator.
// Input channel s_valid/s_ready/s_data carries one 10-bit ADC reading and a
// recalibrate flag per transaction. Output channel m_valid/m_ready/m_data
// returns exactly one result per input: filtered airspeed (Q8.8), pressure
// above the zero offset in pascals, and a calibrating flag.
// Configuration is a write-only port (cfg_wr_en, cfg_index, cfg_wdata):
// index 0 is the low-pass coefficient, index 1 the pitot ratio.
// One transaction is handled at a time. A normal sample spends most of its time
// in the 16-step square root, and the input opens in the cycle after the
// result is loaded. A calibration sample skips the square root and filter,
// and the sample that ends calibration also passes through the reciprocal
// multiply that forms the zero offset.
// After reset (aresetn low, synchronous) the registers hold their defaults
// and the next CAL_LENGTH samples are averaged into the zero offset.
// A finished result sits in the output register; the block takes the next
// input while it waits, and stalls only before loading another result.
module pitot_airspeed_estimator
    import pitot_as_pkg::*;
#(
    parameter int CAL_LENGTH = 100
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    pitot_as_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pitot_as_dp #(
        .CAL_LENGTH (CAL_LENGTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/tb_pitot_airspeed_estimator.sv
`timescale 1ns / 100ps

module tb_pitot_airspeed_estimator;
    import pitot_as_pkg::*;

    localparam int CAL_LEN = 100;
    localparam logic [ADC_BITS-1:0] ADC_MAX = ADC_BITS'(ADC_FS);
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 190;

    // Tracks the zero calibration and the filtered airspeed, and holds the
    // readings that the block still owes.
    class airspeed_tracker;
        logic [COEF_W-1:0] coef_q15;
        logic [COEF_W-1:0] ratio_q412;
        int cal_n;
        int cal_acc;
        int zero_pa;
        bit in_cal;
        logic [FILT_W-1:0] air_q816;
        out_item_t readings_due[$];
        int fails;

        function new();
            coef_q15 = COEF_RESET;
            ratio_q412 = RATIO_RESET;
            cal_n = 0;
            cal_acc = 0;
            zero_pa = 0;
            in_cal = 1'b1;
            air_q816 = '0;
            fails = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LPF_COEF: coef_q15 = val;
                REG_PITOT_RATIO: ratio_q412 = val;
                default: ;
            endcase
        endfunction

        function int pascal_of(logic [ADC_BITS-1:0] adc);
            return (int'(adc) * P_SCALE) / ADC_FS - P_OFFSET;
        endfunction

        // Floor square root, settled one result bit at a time from the top.
        function logic [ROOT_W-1:0] root_of(longint unsigned x);
            logic [ROOT_W-1:0] r;
            logic [ROOT_W-1:0] t;
            longint unsigned tt;
            r = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                t = r | (ROOT_W'(1) << b);
                tt = t;
                if (tt * tt <= x) begin
                    r = t;
                end
            end
            return r;
        endfunction

        function void flag(string msg);
            fails++;
            if (fails <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        // Called for every accepted input transaction.
        function void take_sample(in_item_t it);
            int p;
            int d;
            logic [REL_W-1:0] rel;
            longint unsigned root;
            longint unsigned c;
            longint unsigned old;
            longint unsigned acc;
            out_item_t r;
            p = pascal_of(it.adc_sample);
            if (it.recalibrate) begin
                cal_n = 0;
                cal_acc = 0;
                air_q816 = '0;
                in_cal = 1'b1;
            end
            if (in_cal) begin
                // The sample after a full window closes it without being summed.
                if (cal_n < CAL_LEN) begin
                    cal_n++;
                    cal_acc += p;
                end else begin
                    zero_pa = (cal_n != 0) ? cal_acc / cal_n : 0;
                    in_cal = 1'b0;
                end
                r.airspeed = '0;
                r.relative_pressure = '0;
                r.calibrating = 1'b1;
            end else begin
                d = p - zero_pa;
                rel = (d > 0) ? d[REL_W-1:0] : '0;
                root = root_of(longint'(rel) * ratio_q412 * 16);
                c = (coef_q15 > Q15_ONE) ? Q15_ONE : coef_q15;
                old = air_q816;
                acc = c * old + (Q15_ONE - c) * (root << 8) + 16384;
                acc = acc >> 15;
                air_q816 = (acc > 64'hFF_FFFF) ? '1 : acc[FILT_W-1:0];
                r.airspeed = air_q816[FILT_W-1 -: AIR_W];
                r.relative_pressure = rel;
                r.calibrating = 1'b0;
            end
            readings_due.push_back(r);
        endfunction

        // Called for every accepted result transaction.
        function void compare_reading(out_item_t got);
            out_item_t want;
            if (readings_due.size() == 0) begin
                flag($sformatf("Unexpected result: airspeed=%0d rel=%0d cal=%0b",
                               got.airspeed, got.relative_pressure, got.calibrating));
                return;
            end
            want = readings_due.pop_front();
            if (got.airspeed !== want.airspeed ||
                got.relative_pressure !== want.relative_pressure ||
                got.calibrating !== want.calibrating) begin
                flag($sformatf({"Mismatch: expected airspeed=%0d rel=%0d cal=%0b, ",
                                "got airspeed=%0d rel=%0d cal=%0b"},
                               want.airspeed, want.relative_pressure, want.calibrating,
                               got.airspeed, got.relative_pressure, got.calibrating));
            end
        endfunction

        function void check_drained();
            if (readings_due.size() != 0) begin
                flag($sformatf("%0d expected results never arrived", readings_due.size()));
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    airspeed_tracker trk;
    int src_idle_pct;
    int sink_idle_pct;
    int cal_base;
    int cycles;

    pitot_airspeed_estimator #(
        .CAL_LENGTH(CAL_LEN)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Clock generation.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            trk.compare_reading(m_data);
        end
    end

    function automatic logic [ADC_BITS-1:0] clip_adc(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > ADC_MAX) begin
            return ADC_MAX;
        end
        return v[ADC_BITS-1:0];
    endfunction

    // Level around which a calibration window samples; mostly low so that
    // later samples give a positive relative pressure.
    function automatic int pick_base();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(ADC_MAX);
        end
        return $urandom_range(600);
    endfunction

    // Presents one input transaction and returns at the edge that accepts it.
    task automatic send_item(input logic [ADC_BITS-1:0] adc, input logic recal);
        in_item_t it;
        it.adc_sample = adc;
        it.recalibrate = recal;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        trk.take_sample(it);
    endtask

    // Drops valid and waits until every owed result has come back.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (trk.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        trk.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] coef,
                            input logic [CFG_DATA_W-1:0] ratio);
        settle();
        write_reg(REG_LPF_COEF, coef);
        write_reg(REG_PITOT_RATIO, ratio);
    endtask

    // Random traffic: calibration windows near one level, then samples mostly
    // above it, with the odd restart and the odd outlier.
    task automatic run_phase(input int n_items, input bit force_recal);
        int v;
        logic recal;
        for (int i = 0; i < n_items; i++) begin
            recal = force_recal && (i == 0);
            if (!recal) begin
                recal = trk.in_cal ? ($urandom_range(299) == 0) : ($urandom_range(399) == 0);
            end
            if (recal) begin
                cal_base = pick_base();
            end
            if (trk.in_cal || recal) begin
                if ($urandom_range(49) == 0) begin
                    v = $urandom_range(ADC_MAX);
                end else begin
                    v = cal_base + int'($urandom_range(16)) - 8;
                end
            end else if ($urandom_range(3) == 0) begin
                v = $urandom_range(ADC_MAX);
            end else begin
                v = cal_base + int'($urandom_range(300));
            end
            send_item(clip_adc(v), recal);
        end
    endtask

    initial begin
        trk = new();
        cycles = 0;
        cal_base = pick_base();
        src_idle_pct = 35;
        sink_idle_pct = 46;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset calibration: a full-scale sample, then a restart in the middle
        // of the window, a window of zeros, and a full-scale sample closing it.
        send_item(ADC_MAX, 1'b0);
        send_item('0, 1'b1);
        while (trk.cal_n < CAL_LEN) begin
            send_item('0, 1'b0);
        end
        send_item(ADC_MAX, 1'b0);

        // Offset now sits at the bottom of the range; sweep the converter.
        send_item(ADC_MAX, 1'b0);
        send_item(ADC_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(10'h200, 1'b0);
        send_item(10'h155, 1'b0);
        send_item(10'h2AA, 1'b0);
        send_item(10'h001, 1'b0);

        // Filter bypassed with the largest ratio.
        set_regs('0, 16'hFFFF);
        send_item(ADC_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(ADC_MAX, 1'b0);

        // Filter holding its value, then a coefficient above one.
        set_regs(Q15_ONE, 16'hFFFF);
        send_item(10'h200, 1'b0);
        set_regs(16'hFFFF, '0);
        send_item(ADC_MAX, 1'b0);
        send_item('0, 1'b0);

        // Restart calibration from a normal sample.
        cal_base = pick_base();
        send_item(clip_adc(cal_base), 1'b1);

        set_regs('0, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0);
        set_regs(16'($urandom_range(32768)), 16'($urandom_range(65535)));
        run_phase(PHASE_ITEMS, 1'b0);

        src_idle_pct = 46;
        sink_idle_pct = 35;
        set_regs(16'hFFFF, 16'($urandom_range(65535)));
        run_phase(PHASE_ITEMS, 1'b0);
        set_regs(COEF_RESET, RATIO_RESET);
        run_phase(PHASE_ITEMS, 1'b1);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        set_regs(16'($urandom_range(65535)), '0);
        run_phase(PHASE_ITEMS, 1'b0);
        set_regs(16'($urandom_range(32768)), 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0);

        // Drain and give the block time to show any stray result.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (trk.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        trk.check_drained();
        if (trk.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
